### rtl/thermistor_temperature_converter_core_macros.svh
// assertion helpers used by the checker file
`ifndef THERMISTOR_TEMPERATURE_CONVERTER_CORE_MACROS_SVH
`define THERMISTOR_TEMPERATURE_CONVERTER_CORE_MACROS_SVH

// checked outside reset
`define TTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define TTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/ttc_pkg.sv
package ttc_pkg;

  localparam int ADC_W     = 10;
  localparam int CH_W      = 3;
  localparam int TEMP_W    = 12;
  localparam int RES_W     = 20;
  localparam int T0_W      = 8;
  localparam int BETA_W    = 14;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;

  localparam int ADC_FULL  = 1023;
  localparam int SUM_MAX_W = 14;   // holds 16 * 1023
  localparam int ARG_W     = 34;   // resistance products
  localparam int MANT_W    = 31;
  localparam int FRAC_W    = 24;
  localparam int EXP_W     = 6;
  localparam int LOGV_W    = EXP_W + FRAC_W;
  localparam int LNP_W     = 63;
  localparam int PROD_W    = 48;
  localparam int DD_W      = 49;
  localparam int QUO_W     = 64;
  localparam int REM_W     = 48;
  localparam int TMK_W     = 20;
  localparam int RQ_W      = 41;
  localparam int CNT_W     = 6;

  localparam int LOG_ITERS = 24;
  localparam int DIV_ITERS = 64;

  localparam logic [31:0]     LN2_Q32    = 32'd2977044472;
  localparam logic [15:0]     ZERO_C_CK  = 16'd27315;
  localparam logic [20:0]     ZERO_C_MK  = 21'd273150;
  localparam logic [TMK_W-1:0] TMK_MAX   = 20'd1000000;
  localparam logic [20:0]     RECIP_100  = 21'd1342178;  // ceil(2^27 / 100)
  localparam int              RECIP_SH   = 27;

  localparam logic signed [TEMP_W-1:0] T_LOW  = -12'sd600;
  localparam logic signed [TEMP_W-1:0] T_HIGH = 12'sd2000;

  localparam logic [RES_W-1:0]  SERIES_RST  = 20'd10000;
  localparam logic [RES_W-1:0]  NOMINAL_RST = 20'd10000;
  localparam logic [T0_W-1:0]   T0_RST      = 8'd25;
  localparam logic [BETA_W-1:0] BETA_RST    = 14'd3950;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERIES  = 3'd0,
    REG_NOMINAL = 3'd1,
    REG_T0      = 3'd2,
    REG_BETA    = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ADC_W-1:0] adc_sample;
    logic [CH_W-1:0]  channel;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]          sensor_channel;
    logic signed [TEMP_W-1:0] temperature_tenths;
    logic                     out_of_range;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CHK, S_NORM, S_LOG, S_LOADD, S_DIFF, S_LN,
    S_DD, S_DD2, S_DCHK, S_DIV, S_RND1, S_RND2, S_SAT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACC, OP_MUL, OP_LOAD_N, OP_LOAD_D, OP_NORM, OP_LOGINIT,
    OP_SQR, OP_DIFF, OP_LN, OP_DD, OP_DD2, OP_DIV, OP_RND1, OP_RND2,
    OP_FIN, OP_COLD, OP_HOT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_zero;
    logic num_zero;
    logic den_zero;
    logic norm_done;
    logic dd_pos;
  } dp_status_t;

endpackage

### rtl/ttc_datapath.sv
module ttc_datapath
  import ttc_pkg::*;
#(
  parameter int NUM_SAMPLES = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  in_item_t             in_data_i,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  output out_item_t            out_data_o
);

  localparam int SUM_W = $clog2(NUM_SAMPLES * ADC_FULL + 1);
  localparam int FULL  = NUM_SAMPLES * ADC_FULL;

  logic [RES_W-1:0]        ser_q, nom_q;
  logic signed [T0_W-1:0]  t0_q;
  logic [BETA_W-1:0]       beta_q;
  logic [SUM_W-1:0]        sum_q;
  logic [CH_W-1:0]         chan_q;
  logic [ARG_W-1:0]        num_q, den_q, v_q;
  logic                    sumz_q;
  logic [EXP_W-1:0]        sh_q, e_q;
  logic [MANT_W-1:0]       m_q;
  logic [FRAC_W-1:0]       frac_q;
  logic [LOGV_W-1:0]       lnum_q, mag_q;
  logic                    neg_q, cneg_q;
  logic [LNP_W-1:0]        lnp_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [23:0]             bk_q;
  logic signed [DD_W-1:0]  dd_q;
  logic [REM_W-1:0]        rem_q;
  logic [QUO_W-1:0]        quo_q;
  logic [TMK_W-1:0]        y_q;
  logic [RQ_W-1:0]         rq_q;
  out_item_t               out_q;

  logic signed [16:0]       t0ck_s;
  logic [15:0]              t0ck;
  logic [SUM_MAX_W-1:0]     sum_w, rest_w;
  logic [ARG_W-1:0]         num_p, den_p;
  logic [2*MANT_W-1:0]      sq;
  logic [31:0]              sq_t;
  logic signed [LOGV_W:0]   dif;
  logic signed [LOGV_W:0]   xq;
  logic signed [PROD_W-1:0] prod_p;
  logic [20:0]              b100;
  logic [39:0]              nk;
  logic [REM_W:0]           dsh, trial;
  logic [TMK_W-1:0]         tmk;
  logic signed [20:0]       cval;
  logic [20:0]              cmag;
  logic [13:0]              qv;

  assign t0ck_s = t0_q * 17'sd100 + $signed({1'b0, ZERO_C_CK});
  assign t0ck   = t0ck_s[15:0];
  assign sum_w  = SUM_MAX_W'(sum_q);
  assign rest_w = SUM_MAX_W'(FULL) - sum_w;
  assign num_p  = ARG_W'(ser_q) * ARG_W'(rest_w);
  assign den_p  = ARG_W'(nom_q) * ARG_W'(sum_w);
  assign sq     = (2*MANT_W)'(m_q) * (2*MANT_W)'(m_q);
  assign sq_t   = sq[61:30];
  assign dif    = $signed({1'b0, lnum_q}) - $signed({1'b0, e_q, frac_q});
  assign xq     = neg_q ? -$signed({1'b0, lnp_q[61:32]}) : $signed({1'b0, lnp_q[61:32]});
  assign prod_p = PROD_W'(xq) * PROD_W'($signed({1'b0, t0ck}));
  assign b100   = 21'(beta_q) * 21'd100;
  assign nk     = 40'(bk_q) * 40'(t0ck);
  assign dsh    = {rem_q, quo_q[QUO_W-1]};
  assign trial  = dsh - {1'b0, dd_q[REM_W-1:0]};
  assign tmk    = (quo_q > QUO_W'(TMK_MAX)) ? TMK_MAX : quo_q[TMK_W-1:0];
  assign cval   = $signed({1'b0, tmk}) - $signed(ZERO_C_MK);
  assign cmag   = cval[20] ? 21'(-cval) : 21'(cval);
  assign qv     = rq_q[RQ_W-1:RECIP_SH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_q  <= SERIES_RST;
      nom_q  <= NOMINAL_RST;
      t0_q   <= T0_RST;
      beta_q <= BETA_RST;
      sum_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SERIES:  ser_q  <= cfg_wdata_i[RES_W-1:0];
          REG_NOMINAL: nom_q  <= cfg_wdata_i[RES_W-1:0];
          REG_T0:      t0_q   <= cfg_wdata_i[T0_W-1:0];
          REG_BETA:    beta_q <= cfg_wdata_i[BETA_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_ACC) begin
        sum_q <= sum_q + SUM_W'(in_data_i.adc_sample);
      end else if (cmd_i.op == OP_MUL) begin
        sum_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACC: chan_q <= in_data_i.channel;
      OP_MUL: begin
        num_q  <= num_p;
        den_q  <= den_p;
        sumz_q <= (sum_q == '0);
      end
      OP_LOAD_N: begin
        v_q  <= num_q;
        sh_q <= '0;
      end
      OP_LOAD_D: begin
        lnum_q <= {e_q, frac_q};
        v_q    <= den_q;
        sh_q   <= '0;
      end
      OP_NORM: begin
        v_q  <= v_q << 1;
        sh_q <= sh_q + 1'b1;
      end
      OP_LOGINIT: begin
        m_q    <= v_q[ARG_W-1:ARG_W-MANT_W];
        e_q    <= EXP_W'(ARG_W - 1) - sh_q;
        frac_q <= '0;
      end
      OP_SQR: begin
        m_q    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
        frac_q <= {frac_q[FRAC_W-2:0], sq_t[31]};
      end
      OP_DIFF: begin
        neg_q <= dif[LOGV_W];
        mag_q <= dif[LOGV_W] ? LOGV_W'(-dif) : LOGV_W'(dif);
      end
      OP_LN: lnp_q <= LNP_W'(mag_q) * LNP_W'(LN2_Q32) + (LNP_W'(1) << 31);
      OP_DD: begin
        prod_q <= prod_p;
        bk_q   <= 24'(beta_q) * 24'd1000;
      end
      OP_DD2: begin
        dd_q  <= $signed(DD_W'({b100, 24'b0})) + DD_W'(prod_q);
        quo_q <= {nk, 24'b0};
        rem_q <= '0;
      end
      OP_DIV: begin
        if (!trial[REM_W]) begin
          rem_q <= trial[REM_W-1:0];
          quo_q <= {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_q <= dsh[REM_W-1:0];
          quo_q <= {quo_q[QUO_W-2:0], 1'b0};
        end
      end
      OP_RND1: begin
        cneg_q <= cval[20];
        y_q    <= TMK_W'(cmag + 21'd50);
      end
      OP_RND2: rq_q <= RQ_W'(y_q) * RQ_W'(RECIP_100);
      OP_FIN: begin
        out_q.sensor_channel <= chan_q;
        if (!cneg_q) begin
          if (qv > 14'd2000) begin
            out_q.temperature_tenths <= T_HIGH;
            out_q.out_of_range       <= 1'b1;
          end else begin
            out_q.temperature_tenths <= $signed(TEMP_W'(qv));
            out_q.out_of_range       <= 1'b0;
          end
        end else begin
          if (qv > 14'd600) begin
            out_q.temperature_tenths <= T_LOW;
            out_q.out_of_range       <= 1'b1;
          end else begin
            out_q.temperature_tenths <= -$signed(TEMP_W'(qv));
            out_q.out_of_range       <= 1'b0;
          end
        end
      end
      OP_COLD: begin
        out_q.sensor_channel     <= chan_q;
        out_q.temperature_tenths <= T_LOW;
        out_q.out_of_range       <= 1'b1;
      end
      OP_HOT: begin
        out_q.sensor_channel     <= chan_q;
        out_q.temperature_tenths <= T_HIGH;
        out_q.out_of_range       <= 1'b1;
      end
      default: ;
    endcase
  end

  assign status_o.sum_zero  = sumz_q;
  assign status_o.num_zero  = (num_q == '0);
  assign status_o.den_zero  = (den_q == '0);
  assign status_o.norm_done = v_q[ARG_W-1];
  assign status_o.dd_pos    = !dd_q[DD_W-1] && (dd_q != '0);
  assign out_data_o         = out_q;

endmodule

### rtl/ttc_ctrl.sv
module ttc_ctrl
  import ttc_pkg::*;
#(
  parameter int NUM_SAMPLES = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int IDX_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             which_q, which_d;
  logic             oval_q, oval_d;
  logic             last;

  assign last = (idx_q == IDX_W'(NUM_SAMPLES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      which_q <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      which_q <= which_d;
      oval_q  <= oval_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    which_d    = which_q;
    oval_d     = oval_q && out_stall_i;
    cmd_o.op   = OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        // a finished result must leave before the next group closes
        in_stall_o = oval_q && last;
        if (in_valid_i && !in_stall_o) begin
          cmd_o.op = OP_ACC;
          if (last) begin
            idx_d   = '0;
            state_d = S_MUL;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (status_i.sum_zero || (!status_i.num_zero && status_i.den_zero)) begin
          cmd_o.op = OP_COLD;
          oval_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (status_i.num_zero) begin
          cmd_o.op = OP_HOT;
          oval_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_LOAD_N;
          which_d  = 1'b0;
          state_d  = S_NORM;
        end
      end
      S_NORM: begin
        if (status_i.norm_done) begin
          cmd_o.op = OP_LOGINIT;
          cnt_d    = '0;
          state_d  = S_LOG;
        end else begin
          cmd_o.op = OP_NORM;
        end
      end
      S_LOG: begin
        cmd_o.op = OP_SQR;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(LOG_ITERS - 1)) begin
          state_d = which_q ? S_DIFF : S_LOADD;
        end
      end
      S_LOADD: begin
        cmd_o.op = OP_LOAD_D;
        which_d  = 1'b1;
        state_d  = S_NORM;
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = S_LN;
      end
      S_LN: begin
        cmd_o.op = OP_LN;
        state_d  = S_DD;
      end
      S_DD: begin
        cmd_o.op = OP_DD;
        state_d  = S_DD2;
      end
      S_DD2: begin
        cmd_o.op = OP_DD2;
        state_d  = S_DCHK;
      end
      S_DCHK: begin
        cnt_d = '0;
        if (!status_i.dd_pos) begin
          cmd_o.op = OP_HOT;
          oval_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_ITERS - 1)) begin
          state_d = S_RND1;
        end
      end
      S_RND1: begin
        cmd_o.op = OP_RND1;
        state_d  = S_RND2;
      end
      S_RND2: begin
        cmd_o.op = OP_RND2;
        state_d  = S_SAT;
      end
      S_SAT: begin
        cmd_o.op = OP_FIN;
        oval_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = oval_q;

endmodule

### rtl/thermistor_temperature_converter_core.sv
// samples are taken one per cycle while no group converts; the result of a group
// follows its last sample once the one-bit-per-cycle divider (64 steps) and the shared
// log unit (1 to 33 shift steps at the default group size and 24 squarings, run twice)
// are through; a zero sum or zero resistance product skips them for a clamped result
// while a group converts no sample is taken; a waiting result holds off the last sample
// reset clears the running sum, sample count and control state, loads default calibration
module thermistor_temperature_converter_core
  import ttc_pkg::*;
#(
  parameter int NUM_SAMPLES = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ttc_ctrl #(
    .NUM_SAMPLES(NUM_SAMPLES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ttc_datapath #(
    .NUM_SAMPLES(NUM_SAMPLES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

### rtl/ttc_checker.sv
`include "thermistor_temperature_converter_core_macros.svh"

module ttc_checker
  import ttc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  `TTC_ASSERT(temp_in_range, out_valid_o |-> (out_data_o.temperature_tenths >= T_LOW && out_data_o.temperature_tenths <= T_HIGH), "temperature outside saturation limits")
  `TTC_ASSERT_ALWAYS(no_result_in_reset, !rst_ni |-> !out_valid_o, "result valid during reset")
  `TTC_ASSERT(result_after_busy, $rose(out_valid_o) |-> $past(in_stall_o), "result appeared without a conversion")
  `TTC_ASSERT(stalled_result_holds, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result dropped or changed")

endmodule

bind thermistor_temperature_converter_core ttc_checker u_ttc_checker (.*);
